// ===== src/ile_pkg.sv =====
// shared types and constants for the indexed list engine
// request and response beat structs, operation and result codes, sequencer states
package ile_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int WORD_WIDTH       = 32;
   localparam int POS_WIDTH        = 7;

   typedef enum logic [2:0] {
      OP_APPEND   = 3'd0,
      OP_POP      = 3'd1,
      OP_INSERT   = 3'd2,
      OP_ERASE    = 3'd3,
      OP_SIZE     = 3'd4,
      OP_LIST     = 3'd5,
      OP_LIST_REV = 3'd6,
      OP_READ     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      KIND_COUNT   = 3'd0,
      KIND_LISTED  = 3'd1,
      KIND_READ    = 3'd2,
      KIND_INVALID = 3'd3,
      KIND_EMPTY   = 3'd4,
      KIND_FULL    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TAIL,
      ST_PLACE,
      ST_READ
   } state_type;

   typedef struct packed {
      op_type                        operation;
      logic [POS_WIDTH-1:0]          position;
      logic signed [WORD_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [WORD_WIDTH-1:0]  data;
      logic                          last;
   } rsp_type;

endpackage

// ===== src/ile_store.sv =====
// element store: one write port, one read port with registered read data
// depends on ile_pkg for the word width and the default depth
module ile_store #(
   parameter int DEPTH = ile_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [AW-1:0]                         wr_addr,
   input  logic signed [ile_pkg::WORD_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]                         rd_addr,
   output logic signed [ile_pkg::WORD_WIDTH-1:0] rd_data
);

   logic signed [ile_pkg::WORD_WIDTH-1:0] mem [DEPTH];
   logic signed [ile_pkg::WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/indexed_list_engine.sv =====
// indexed list engine: append, pop, insert, erase, size, list, list reversed, read.
// append, pop, size and rejected or ignored requests finish in idle; read uses ST_READ.
// insert and erase move one element per cycle; insert then writes its value in ST_PLACE.
// listing gives one beat per cycle; the single store port sets the pace.
// the receiver cannot stall; results leave on a registered strobe after the store read.
// synchronous reset empties the list; store contents stay undefined until written.
module indexed_list_engine #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ile_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ile_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   ile_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               have_ff, have_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      src_ff, src_in;
   logic [AW-1:0]      end_ff, end_in;
   logic               down_ff, down_in;
   ile_pkg::op_type    op_ff, op_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [ile_pkg::WORD_WIDTH-1:0] val_ff, val_in;
   ile_pkg::rsp_type   rsp_ff, rsp_in;

   logic                                  wr_en;
   logic [AW-1:0]                         wr_addr;
   logic signed [ile_pkg::WORD_WIDTH-1:0] wr_data;
   logic [AW-1:0]                         rd_addr;
   logic signed [ile_pkg::WORD_WIDTH-1:0] rd_data;

   logic [7:0]    cnt8;
   logic [7:0]    pos8;
   logic          full;
   logic [AW-1:0] count_last;
   logic [AW-1:0] pos_a;
   logic          listing;

   ile_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt8       = 8'(count_ff);
   assign pos8       = 8'(req_data.position);
   assign full       = (count_ff == CW'(CAPACITY));
   assign count_last = AW'(count_ff - CW'(1));
   assign pos_a      = req_data.position[AW-1:0];
   assign listing    = (op_ff == ile_pkg::OP_LIST) || (op_ff == ile_pkg::OP_LIST_REV);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      have_in      = have_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      end_in       = end_ff;
      down_in      = down_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{kind: ile_pkg::KIND_COUNT, data: '0, last: 1'b1};
      // moves go against the walk: walking down shifts up, walking up shifts down
      wr_en        = 1'b0;
      wr_addr      = down_ff ? src_ff + AW'(1) : src_ff - AW'(1);
      wr_data      = rd_data;
      rd_addr      = idx_ff;

      case (state_ff)
         ile_pkg::ST_IDLE: begin
            rd_addr = pos_a;
            have_in = 1'b0;
            if (start) begin
               op_in  = req_data.operation;
               pos_in = pos_a;
               val_in = req_data.value;
               case (req_data.operation)
                  ile_pkg::OP_APPEND: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = ile_pkg::KIND_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_data.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ile_pkg::OP_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ile_pkg::OP_INSERT: begin
                     if (pos8 <= cnt8) begin
                        if (full) begin
                           rsp_valid_in = 1'b1;
                           rsp_in.kind  = ile_pkg::KIND_FULL;
                        end else if (pos8 == cnt8) begin
                           wr_en    = 1'b1;
                           wr_addr  = pos_a;
                           wr_data  = req_data.value;
                           count_in = count_ff + CW'(1);
                        end else begin
                           idx_in   = count_last;
                           end_in   = pos_a;
                           down_in  = 1'b1;
                           state_in = ile_pkg::ST_WALK;
                        end
                     end
                  end
                  ile_pkg::OP_ERASE: begin
                     if (pos8 < cnt8) begin
                        if (pos8 + 8'd1 == cnt8) begin
                           count_in = count_ff - CW'(1);
                        end else begin
                           idx_in   = pos_a + AW'(1);
                           end_in   = count_last;
                           down_in  = 1'b0;
                           state_in = ile_pkg::ST_WALK;
                        end
                     end
                  end
                  ile_pkg::OP_SIZE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = ile_pkg::KIND_COUNT;
                     rsp_in.data  = ile_pkg::WORD_WIDTH'(count_ff);
                  end
                  ile_pkg::OP_LIST, ile_pkg::OP_LIST_REV: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = ile_pkg::KIND_EMPTY;
                     end else if (req_data.operation == ile_pkg::OP_LIST) begin
                        idx_in   = '0;
                        end_in   = count_last;
                        down_in  = 1'b0;
                        state_in = ile_pkg::ST_WALK;
                     end else begin
                        idx_in   = count_last;
                        end_in   = '0;
                        down_in  = 1'b1;
                        state_in = ile_pkg::ST_WALK;
                     end
                  end
                  ile_pkg::OP_READ: begin
                     if (pos8 >= cnt8) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = ile_pkg::KIND_INVALID;
                     end else begin
                        state_in = ile_pkg::ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ile_pkg::ST_WALK: begin
            // the word read last cycle is either sent out or moved one place
            if (have_ff) begin
               if (listing) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = ile_pkg::KIND_LISTED;
                  rsp_in.data  = rd_data;
                  rsp_in.last  = 1'b0;
               end else begin
                  wr_en = 1'b1;
               end
            end
            src_in  = idx_ff;
            have_in = 1'b1;
            if (idx_ff == end_ff) begin
               state_in = ile_pkg::ST_TAIL;
            end else begin
               idx_in = down_ff ? idx_ff - AW'(1) : idx_ff + AW'(1);
            end
         end

         ile_pkg::ST_TAIL: begin
            have_in = 1'b0;
            if (listing) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = ile_pkg::KIND_LISTED;
               rsp_in.data  = rd_data;
               state_in     = ile_pkg::ST_IDLE;
            end else begin
               wr_en = 1'b1;
               if (op_ff == ile_pkg::OP_INSERT) begin
                  state_in = ile_pkg::ST_PLACE;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = ile_pkg::ST_IDLE;
               end
            end
         end

         ile_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            state_in = ile_pkg::ST_IDLE;
         end

         ile_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = ile_pkg::KIND_READ;
            rsp_in.data  = rd_data;
            state_in     = ile_pkg::ST_IDLE;
         end

         default: begin
            state_in = ile_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ile_pkg::ST_IDLE;
         count_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      src_ff  <= src_in;
      end_ff  <= end_in;
      down_ff <= down_in;
      op_ff   <= op_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ile_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
